/* hdl/blsd_pkg.sv */
// Shared types and constants for the bounded list with search and delete.
// Holds command and status codes, datapath operations and the control structs.
// Depends on nothing; every other file of the block imports it.
package blsd_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CMD_W         = 3;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_REM_FRONT = 3'd2,
        CMD_REM_BACK  = 3'd3,
        CMD_SEARCH    = 3'd4,
        CMD_REM_VALUE = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // One datapath operation per cycle, chosen by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_SCAN_START,
        OP_READ,
        OP_NEXT,
        OP_SHIFT_READ,
        OP_SHIFT_WRITE,
        OP_DROP
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    respond;
        status_t status;
        logic    found;
    } blsd_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic match;
        logic last;
    } blsd_stat_t;

endpackage

/* hdl/blsd_ctrl.sv */
// Controller state machine for the bounded list.
// Decodes requests and sequences scans and gap-closing shifts in the datapath.
// Depends on blsd_pkg.
module blsd_ctrl
    import blsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CMD_W-1:0]     command,
    input  blsd_stat_t           stat,
    output blsd_ctl_t            ctl,
    output logic                 busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SRD,
        S_SWR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_del_reg;
    logic   is_del_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            is_del_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            is_del_reg <= is_del_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        is_del_next = is_del_reg;
        ctl.op      = OP_NONE;
        ctl.respond = 1'b0;
        ctl.status  = ST_OK;
        ctl.found   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.respond = 1'b1;
                    unique case (command)
                        CMD_INS_FRONT, CMD_INS_BACK:
                        begin
                            if (stat.full)
                                ctl.status = ST_FULL;
                            else
                                ctl.op = (command == CMD_INS_FRONT) ? OP_PUSH_FRONT
                                                                    : OP_PUSH_BACK;
                        end
                        CMD_REM_FRONT, CMD_REM_BACK:
                        begin
                            if (stat.empty)
                                ctl.status = ST_EMPTY;
                            else
                                ctl.op = (command == CMD_REM_FRONT) ? OP_POP_FRONT
                                                                    : OP_POP_BACK;
                        end
                        CMD_SEARCH, CMD_REM_VALUE:
                        begin
                            if (stat.empty)
                            begin
                                ctl.status = (command == CMD_SEARCH) ? ST_NOTFOUND
                                                                     : ST_EMPTY;
                            end
                            else
                            begin
                                ctl.respond = 1'b0;
                                ctl.op      = OP_SCAN_START;
                                is_del_next = (command == CMD_REM_VALUE);
                                state_next  = S_RD;
                            end
                        end
                        default:
                        begin
                            ctl.status = ST_OK;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                ctl.op     = OP_READ;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (stat.match)
                begin
                    if (is_del_reg)
                    begin
                        state_next = S_SRD;
                    end
                    else
                    begin
                        ctl.respond = 1'b1;
                        ctl.found   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (stat.last)
                begin
                    ctl.respond = 1'b1;
                    ctl.status  = ST_NOTFOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.op     = OP_NEXT;
                    state_next = S_RD;
                end
            end
            S_SRD:
            begin
                if (stat.last)
                begin
                    // Every later element has moved forward; shorten the list.
                    ctl.op      = OP_DROP;
                    ctl.respond = 1'b1;
                    ctl.found   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.op     = OP_SHIFT_READ;
                    state_next = S_SWR;
                end
            end
            S_SWR:
            begin
                ctl.op     = OP_SHIFT_WRITE;
                state_next = S_SRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A read state is always followed by the compare state.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |=> state_reg == S_CMP)
        else $error("read state not followed by compare");

endmodule

/* hdl/blsd_dp.sv */
// Datapath of the bounded list: circular element memory, head and count,
// scan index, captured search value and the registered result.
// Depends on blsd_pkg.
module blsd_dp
    import blsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [VALUE_W-1:0]   value,
    input  blsd_ctl_t            ctl,
    output blsd_stat_t           stat,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic                 found,
    output logic [COUNT_W-1:0]   count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = IDX_W + 1;

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               done_reg;
    status_t            status_reg;
    logic               found_reg;

    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   waddr;
    logic [IDX_W-1:0]   raddr;
    logic [VALUE_W-1:0] wdata;
    logic [IDX_W-1:0]   head_dec;
    logic [IDX_W-1:0]   head_inc;
    logic [IDX_W-1:0]   idx_inc;

    // Logical position to physical slot; the sum stays below twice the depth.
    function automatic logic [IDX_W-1:0] wrap(input logic [AW-1:0] sum);
        logic [AW-1:0] s;
        s = (sum >= AW'(DEPTH)) ? sum - AW'(DEPTH) : sum;
        return s[IDX_W-1:0];
    endfunction

    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - IDX_W'(1);
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign idx_inc  = idx_reg + IDX_W'(1);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        waddr      = wrap(AW'(head_reg) + AW'(idx_reg));
        raddr      = wrap(AW'(head_reg) + AW'(idx_reg));
        wdata      = rd_data_reg;
        unique case (ctl.op)
            OP_PUSH_FRONT:
            begin
                head_next  = head_dec;
                count_next = count_reg + CNT_W'(1);
                mem_we     = 1'b1;
                waddr      = head_dec;
                wdata      = value;
            end
            OP_PUSH_BACK:
            begin
                count_next = count_reg + CNT_W'(1);
                mem_we     = 1'b1;
                waddr      = wrap(AW'(head_reg) + AW'(count_reg));
                wdata      = value;
            end
            OP_POP_FRONT:
            begin
                head_next  = head_inc;
                count_next = count_reg - CNT_W'(1);
            end
            OP_POP_BACK, OP_DROP:
            begin
                count_next = count_reg - CNT_W'(1);
            end
            OP_SCAN_START:
            begin
                idx_next = '0;
            end
            OP_READ:
            begin
                mem_re = 1'b1;
            end
            OP_NEXT:
            begin
                idx_next = idx_inc;
            end
            OP_SHIFT_READ:
            begin
                mem_re = 1'b1;
                raddr  = wrap(AW'(head_reg) + AW'(idx_reg) + AW'(1));
            end
            OP_SHIFT_WRITE:
            begin
                mem_we   = 1'b1;
                idx_next = idx_inc;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= ctl.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctl.op == OP_SCAN_START)
            value_reg <= value;
        if (ctl.respond)
        begin
            status_reg <= ctl.status;
            found_reg  <= ctl.found;
        end
    end

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.match = (rd_data_reg == value_reg);
    assign stat.last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign done   = done_reg;
    assign status = status_reg;
    assign found  = found_reg;
    assign count  = COUNT_W'(count_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_PUSH_FRONT || ctl.op == OP_PUSH_BACK) |-> !stat.full)
        else $error("insert into a full list");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_POP_FRONT || ctl.op == OP_POP_BACK || ctl.op == OP_DROP)
        |-> !stat.empty)
        else $error("removal from an empty list");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && found_reg |-> status_reg == ST_OK)
        else $error("found flag with a failing status");

endmodule

/* hdl/bounded_list_with_search_delete.sv */
// Top level of the bounded list with search and delete by value.
// Joins the controller (blsd_ctrl) and the datapath (blsd_dp); uses blsd_pkg.
//
// A request is taken at a rising edge with start high and busy low; its single
// result (status, found, count) is registered and shown with done high for
// exactly one cycle, and the receiver cannot hold it off. Insert front, insert
// back, remove front, remove back, refused requests and the unused command
// codes answer in the next cycle; busy stays low and a new request may follow
// every cycle. Search and remove-value walk the list through the single-port
// element memory, whose read data is registered, through a read and a compare
// state per element up to the first match or the end of the list; remove-value
// then closes the gap by moving each later element forward through a shift-read
// and a shift-write state, then shortens the list. The list is a ring around a
// head pointer, so no clearing pass is needed after reset. The count port
// carries the low five bits of the element count.
module bounded_list_with_search_delete
    import blsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CMD_W-1:0]     command,
    input  logic [VALUE_W-1:0]   value,
    output logic                 busy,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic                 found,
    output logic [COUNT_W-1:0]   count
);

    blsd_ctl_t  ctl;
    blsd_stat_t stat;

    // Controller: decodes each request and steps the scans and shifts.
    blsd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy)
    );

    // Datapath: element ring, head, count and the registered result.
    blsd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .ctl    (ctl),
        .stat   (stat),
        .done   (done),
        .status (status),
        .found  (found),
        .count  (count)
    );

    // A request other than search or remove-value always reports on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !(command == CMD_SEARCH || command == CMD_REM_VALUE)
        |=> done)
        else $error("single-cycle request gave no result");

    // A result is only shown when the block is ready for the next request.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

endmodule
